@@ rtl/escaped_command_line_tokenizer_macros.svh @@
// Assertion helpers for the command line tokenizer.
// Both sample on the rising clock and are disabled while reset is high.
`ifndef ESCAPED_COMMAND_LINE_TOKENIZER_MACROS_SVH
`define ESCAPED_COMMAND_LINE_TOKENIZER_MACROS_SVH

// Same-cycle implication.
`define ECLT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ECLT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/ecltok_pkg.sv @@
package ecltok_pkg;

   localparam int PENDING_DEPTH = 8;
   // at most 12 held bytes, fewer when PENDING_DEPTH is smaller
   localparam int PEND_CAP = (PENDING_DEPTH < 12) ? PENDING_DEPTH : 12;
   localparam int CNT_W = $clog2(PEND_CAP + 1);
   localparam int IDX_W = (PEND_CAP > 1) ? $clog2(PEND_CAP) : 1;

   localparam int TDATA_W = 16;
   localparam int TUSER_W = 5;

   // result kinds
   localparam logic [2:0] K_CHAR      = 3'd0;
   localparam logic [2:0] K_PARAM_END = 3'd1;
   localparam logic [2:0] K_ROW_END   = 3'd2;
   localparam logic [2:0] K_CMD_END   = 3'd3;
   localparam logic [2:0] K_ERROR     = 3'd4;

   // character classes
   localparam logic [1:0] CLS_NAME  = 2'd0;
   localparam logic [1:0] CLS_KEY   = 2'd1;
   localparam logic [1:0] CLS_VALUE = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_EMPTY_CMD  = 3'd1;
   localparam logic [2:0] ERR_NO_NAME    = 3'd2;
   localparam logic [2:0] ERR_EMPTY_ROW  = 3'd3;
   localparam logic [2:0] ERR_NO_KEY     = 3'd4;
   localparam logic [2:0] ERR_ESC_CUT    = 3'd5;
   localparam logic [2:0] ERR_BAD_ESC    = 3'd6;

   // characters
   localparam logic [7:0] CH_PIPE  = 8'h7C;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   typedef enum logic [2:0] {
      OP_NONE    = 3'd0,
      OP_LOAD    = 3'd1,
      OP_STORE   = 3'd2,
      OP_REPLAY  = 3'd3,
      OP_PROC    = 3'd4,
      OP_FIN     = 3'd5,
      OP_FIN_CMD = 3'd6,
      OP_FLUSH   = 3'd7
   } op_type;

   typedef struct packed {
      op_type op;
      logic   go;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;     // output register can take a result this cycle
      logic in_crlf;      // byte on the input port is CR or LF
      logic in_eoc;       // end flag on the input port
      logic eoc;          // end flag of the transaction being worked
      logic pend_empty;
      logic replay_last;  // replaying the last held byte
      logic step_done;
      logic fin_to_cmd;   // close emitted the row end, command end follows
   } dp_status_type;

endpackage

@@ rtl/ecltok_ctrl.sv @@
module ecltok_ctrl import ecltok_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_STORE   = 7'b0000010,
      ST_REPLAY  = 7'b0000100,
      ST_PROC    = 7'b0001000,
      ST_FIN     = 7'b0010000,
      ST_FIN_CMD = 7'b0100000,
      ST_FLUSH   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd.op     = OP_NONE;
      cmd.go     = status.out_free;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.op     = OP_LOAD;
            cmd.go     = req_tvalid;
            if (req_tvalid) begin
               if (status.in_crlf) begin
                  state_in = status.in_eoc ? ST_FIN : ST_STORE;
               end else begin
                  state_in = status.pend_empty ? ST_PROC : ST_REPLAY;
               end
            end
         end
         ST_STORE: begin
            cmd.op = OP_STORE;
            if (status.out_free) begin
               state_in = ST_FLUSH;
            end
         end
         ST_REPLAY: begin
            cmd.op = OP_REPLAY;
            if (status.out_free && status.step_done && status.replay_last) begin
               state_in = ST_PROC;
            end
         end
         ST_PROC: begin
            cmd.op = OP_PROC;
            if (status.out_free && status.step_done) begin
               state_in = status.eoc ? ST_FIN : ST_FLUSH;
            end
         end
         ST_FIN: begin
            cmd.op = OP_FIN;
            if (status.out_free && status.step_done) begin
               state_in = status.fin_to_cmd ? ST_FIN_CMD : ST_FLUSH;
            end
         end
         ST_FIN_CMD: begin
            cmd.op = OP_FIN_CMD;
            if (status.out_free) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            cmd.op = OP_FLUSH;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            cmd.go   = 1'b0;
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/ecltok_dp.sv @@
module ecltok_dp import ecltok_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         req_tdata,
   input  logic               req_tlast,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,
   output logic [TUSER_W-1:0] rsp_tuser,
   output logic               rsp_tlast,
   input  dp_cmd_type         cmd,
   output dp_status_type      status
);

   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_NAME  = 2'd1,
      PH_SKIP  = 2'd2,
      PH_DATA  = 2'd3
   } phase_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [1:0] cls;
      logic [7:0] ch;
      logic [2:0] err;
   } res_type;

   // returns {valid, decoded}
   function automatic logic [8:0] decode_escape(input logic [7:0] c);
      logic [8:0] r;
      case (c)
         CH_BSL:   r = {1'b1, CH_BSL};
         CH_SLASH: r = {1'b1, CH_SLASH};
         8'h73:    r = {1'b1, CH_SP};     // s
         8'h70:    r = {1'b1, CH_PIPE};   // p
         8'h61:    r = {1'b1, 8'd7};      // a
         8'h62:    r = {1'b1, 8'd8};      // b
         8'h66:    r = {1'b1, 8'd12};     // f
         8'h6E:    r = {1'b1, CH_LF};     // n
         8'h72:    r = {1'b1, CH_CR};     // r
         8'h74:    r = {1'b1, 8'd9};      // t
         8'h76:    r = {1'b1, 8'd11};     // v
         default:  r = 9'd0;
      endcase
      return r;
   endfunction

   phase_type        ph_ff, ph_in;
   logic             ep_ff, ep_in;
   logic             po_ff, po_in;
   logic             iv_ff, iv_in;
   logic             rn_ff, rn_in;
   logic             es_ff, es_in;
   logic [CNT_W-1:0] pend_cnt_ff, pend_cnt_in;
   logic             pend_bits_ff [PEND_CAP];
   logic [IDX_W-1:0] rep_idx_ff, rep_idx_in;
   logic [7:0]       byte_ff;
   logic             eoc_ff;
   logic             held_valid_ff, held_valid_in;
   res_type          held_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   res_type          rsp_res_ff;
   logic             rsp_last_ff;

   logic       emit, done, to_cmd, take_data, store_we, push, push_last;
   res_type    res;
   logic [7:0] c;
   logic [8:0] dec;
   logic       replay_last;

   assign replay_last = (CNT_W'(rep_idx_ff) + CNT_W'(1)) == pend_cnt_ff;
   assign c = (cmd.op == OP_REPLAY) ? (pend_bits_ff[rep_idx_ff] ? CH_LF : CH_CR) : byte_ff;
   assign dec = decode_escape(c);

   always_comb begin
      ph_in     = ph_ff;
      ep_in     = ep_ff;
      po_in     = po_ff;
      iv_in     = iv_ff;
      rn_in     = rn_ff;
      es_in     = es_ff;
      emit      = 1'b0;
      res       = '0;
      done      = 1'b1;
      to_cmd    = 1'b0;
      take_data = 1'b0;
      store_we  = 1'b0;
      case (cmd.op)
         OP_STORE: begin
            if (!es_ff) begin
               if (pend_cnt_ff >= CNT_W'(PEND_CAP)) begin
                  emit     = 1'b1;
                  res.kind = K_ERROR;
                  res.err  = ERR_BAD_ESC;
                  es_in    = 1'b1;
               end else begin
                  store_we = 1'b1;
               end
            end
         end
         OP_REPLAY, OP_PROC: begin
            if (!es_ff) begin
               case (ph_ff)
                  PH_START: begin
                     emit = 1'b1;
                     if (c == CH_SP) begin
                        res.kind = K_ERROR;
                        res.err  = ERR_NO_NAME;
                        es_in    = 1'b1;
                     end else begin
                        res.kind = K_CHAR;
                        res.cls  = CLS_NAME;
                        res.ch   = c;
                        ph_in    = PH_NAME;
                     end
                  end
                  PH_NAME: begin
                     if (c == CH_SP) begin
                        ph_in = PH_SKIP;
                     end else begin
                        emit     = 1'b1;
                        res.kind = K_CHAR;
                        res.cls  = CLS_NAME;
                        res.ch   = c;
                     end
                  end
                  PH_SKIP: begin
                     if (c != CH_SP) begin
                        ph_in     = PH_DATA;
                        po_in     = 1'b0;
                        iv_in     = 1'b0;
                        ep_in     = 1'b0;
                        rn_in     = 1'b0;
                        take_data = 1'b1;
                     end
                  end
                  default: take_data = 1'b1;
               endcase
               // data byte, worked on the *_in view so a fresh row starts clean
               if (take_data) begin
                  if (c == CH_PIPE) begin
                     if (!rn_in) begin
                        emit     = 1'b1;
                        res.kind = K_ERROR;
                        res.err  = ERR_EMPTY_ROW;
                        es_in    = 1'b1;
                     end else if (po_in && ep_in) begin
                        emit     = 1'b1;
                        res.kind = K_ERROR;
                        res.err  = ERR_ESC_CUT;
                        es_in    = 1'b1;
                     end else if (po_in) begin
                        // parameter end now, same byte again for the row end
                        emit     = 1'b1;
                        res.kind = K_PARAM_END;
                        po_in    = 1'b0;
                        iv_in    = 1'b0;
                        ep_in    = 1'b0;
                        done     = 1'b0;
                     end else begin
                        emit     = 1'b1;
                        res.kind = K_ROW_END;
                        rn_in    = 1'b0;
                        iv_in    = 1'b0;
                        ep_in    = 1'b0;
                     end
                  end else begin
                     rn_in = 1'b1;
                     if (c == CH_SP) begin
                        if (po_in) begin
                           emit = 1'b1;
                           if (ep_in) begin
                              res.kind = K_ERROR;
                              res.err  = ERR_ESC_CUT;
                              es_in    = 1'b1;
                           end else begin
                              res.kind = K_PARAM_END;
                           end
                        end
                        po_in = 1'b0;
                        iv_in = 1'b0;
                        ep_in = 1'b0;
                     end else if (!po_in) begin
                        po_in = 1'b1;
                        iv_in = 1'b0;
                        ep_in = 1'b0;
                        emit  = 1'b1;
                        if (c == CH_EQ) begin
                           res.kind = K_ERROR;
                           res.err  = ERR_NO_KEY;
                           es_in    = 1'b1;
                        end else begin
                           res.kind = K_CHAR;
                           res.cls  = CLS_KEY;
                           res.ch   = c;
                        end
                     end else if (!iv_in) begin
                        if (c == CH_EQ) begin
                           iv_in = 1'b1;
                        end else begin
                           emit     = 1'b1;
                           res.kind = K_CHAR;
                           res.cls  = CLS_KEY;
                           res.ch   = c;
                        end
                     end else if (ep_in) begin
                        ep_in = 1'b0;
                        emit  = 1'b1;
                        if (!dec[8]) begin
                           res.kind = K_ERROR;
                           res.err  = ERR_BAD_ESC;
                           es_in    = 1'b1;
                        end else begin
                           res.kind = K_CHAR;
                           res.cls  = CLS_VALUE;
                           res.ch   = dec[7:0];
                        end
                     end else if (c == CH_BSL) begin
                        ep_in = 1'b1;
                     end else begin
                        emit     = 1'b1;
                        res.kind = K_CHAR;
                        res.cls  = CLS_VALUE;
                        res.ch   = c;
                     end
                  end
               end
            end
         end
         OP_FIN: begin
            if (!es_ff) begin
               emit = 1'b1;
               case (ph_ff)
                  PH_START: begin
                     res.kind = K_ERROR;
                     res.err  = ERR_EMPTY_CMD;
                     es_in    = 1'b1;
                  end
                  PH_NAME, PH_SKIP: res.kind = K_CMD_END;
                  default: begin
                     if (!rn_ff) begin
                        res.kind = K_ERROR;
                        res.err  = ERR_EMPTY_ROW;
                        es_in    = 1'b1;
                     end else if (po_ff && ep_ff) begin
                        res.kind = K_ERROR;
                        res.err  = ERR_ESC_CUT;
                        es_in    = 1'b1;
                     end else if (po_ff) begin
                        res.kind = K_PARAM_END;
                        po_in    = 1'b0;
                        iv_in    = 1'b0;
                        ep_in    = 1'b0;
                        done     = 1'b0;
                     end else begin
                        res.kind = K_ROW_END;
                        rn_in    = 1'b0;
                        to_cmd   = 1'b1;
                     end
                  end
               endcase
            end
         end
         OP_FIN_CMD: begin
            emit     = 1'b1;
            res.kind = K_CMD_END;
         end
         default: ;
      endcase
   end

   // result held back one step so the last one of a transaction can be marked
   always_comb begin
      held_valid_in = held_valid_ff;
      push          = 1'b0;
      push_last     = 1'b0;
      if (cmd.go) begin
         if (cmd.op == OP_FLUSH) begin
            push          = held_valid_ff;
            push_last     = 1'b1;
            held_valid_in = 1'b0;
         end else if (emit) begin
            push          = held_valid_ff;
            held_valid_in = 1'b1;
         end
      end
      rsp_valid_in = push ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_comb begin
      pend_cnt_in = pend_cnt_ff;
      rep_idx_in  = rep_idx_ff;
      if (cmd.go) begin
         case (cmd.op)
            OP_LOAD: rep_idx_in = '0;
            OP_STORE: begin
               if (store_we) begin
                  pend_cnt_in = pend_cnt_ff + CNT_W'(1);
               end
            end
            OP_REPLAY: begin
               if (done) begin
                  rep_idx_in = rep_idx_ff + IDX_W'(1);
                  if (replay_last) begin
                     pend_cnt_in = '0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff         <= PH_START;
         ep_ff         <= 1'b0;
         po_ff         <= 1'b0;
         iv_ff         <= 1'b0;
         rn_ff         <= 1'b0;
         es_ff         <= 1'b0;
         pend_cnt_ff   <= '0;
         rep_idx_ff    <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         held_valid_ff <= held_valid_in;
         rep_idx_ff    <= rep_idx_in;
         if (cmd.go && (cmd.op == OP_FLUSH) && eoc_ff) begin
            ph_ff       <= PH_START;
            ep_ff       <= 1'b0;
            po_ff       <= 1'b0;
            iv_ff       <= 1'b0;
            rn_ff       <= 1'b0;
            es_ff       <= 1'b0;
            pend_cnt_ff <= '0;
         end else begin
            pend_cnt_ff <= pend_cnt_in;
            if (cmd.go) begin
               ph_ff <= ph_in;
               ep_ff <= ep_in;
               po_ff <= po_in;
               iv_ff <= iv_in;
               rn_ff <= rn_in;
               es_ff <= es_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.go && (cmd.op == OP_LOAD)) begin
         byte_ff <= req_tdata;
         eoc_ff  <= req_tlast;
      end
      if (cmd.go && store_we) begin
         pend_bits_ff[pend_cnt_ff[IDX_W-1:0]] <= (byte_ff == CH_LF);
      end
      if (cmd.go && emit && (cmd.op != OP_FLUSH)) begin
         held_ff <= res;
      end
      if (push) begin
         rsp_res_ff  <= held_ff;
         rsp_last_ff <= push_last;
      end
   end

   assign status.out_free    = !rsp_valid_ff || rsp_tready;
   assign status.in_crlf     = (req_tdata == CH_CR) || (req_tdata == CH_LF);
   assign status.in_eoc      = req_tlast;
   assign status.eoc         = eoc_ff;
   assign status.pend_empty  = pend_cnt_ff == '0;
   assign status.replay_last = replay_last;
   assign status.step_done   = done;
   assign status.fin_to_cmd  = to_cmd;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_res_ff.err, rsp_res_ff.ch};
   assign rsp_tuser  = {rsp_res_ff.cls, rsp_res_ff.kind};
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ rtl/escaped_command_line_tokenizer.sv @@
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  tdata: in_byte; tlast: end_of_command
// rsp       out        rsp_tvalid/rsp_tready  tdata: out_char, error_code;
//                                             tuser: kind, char_class; tlast: run_last
//
// One byte at a time: the byte is accepted, each held CR/LF is replayed ahead of it,
// then a CR/LF is stored unless it ends the command, or any other byte is worked (a '|'
// that also closes a parameter takes a second step), the end-of-command close runs
// when tlast is set, and the last result is released.
// Reset is synchronous and clears all control state; the CR/LF store needs none.
// Every step after the accept waits while the output register holds a result not yet taken.
`include "escaped_command_line_tokenizer_macros.svh"

module escaped_command_line_tokenizer import ecltok_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // [7:0] in_byte
   input  logic               req_tlast,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,   // [7:0] out_char, [10:8] error_code
   output logic [TUSER_W-1:0] rsp_tuser,   // [2:0] kind, [4:3] char_class
   output logic               rsp_tlast
);

   dp_cmd_type    cmd;
   dp_status_type status;

   ecltok_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ecltok_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

   `ECLT_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "ready held after accept")
   `ECLT_ASSERT_SAME(a_error_has_code, rsp_tvalid && (rsp_tuser[2:0] == K_ERROR), rsp_tdata[10:8] != ERR_NONE, "error without code")
   `ECLT_ASSERT_SAME(a_mark_is_blank, rsp_tvalid && (rsp_tuser[2:0] != K_CHAR), (rsp_tdata[7:0] == 8'h00) && (rsp_tuser[4:3] == CLS_NAME), "mark carries a character")

endmodule
